// ----- hdl/lse_pkg.sv -----
package lse_pkg;

    localparam int NUM_TERMS = 8;
    localparam int ORDERS    = 8;
    localparam int NUM_STAGES = 18;

    localparam int MU_W   = 18;
    localparam int COEF_W = 21;
    localparam int OUT_W  = 24;
    localparam int PW     = 20;
    localparam int TW     = 24;
    localparam int AW     = 44;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic signed [PW-1:0] ONE_Q16 = 20'sd65536;
    localparam logic signed [PW-1:0] MONE_Q16 = -20'sd65536;

    localparam logic signed [18:0] RECIP_5 = 19'sd209715;
    localparam logic signed [18:0] RECIP_6 = 19'sd174763;
    localparam logic signed [18:0] RECIP_7 = 19'sd149797;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sd8388607;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -24'sd8388608;

    localparam logic signed [COEF_W-1:0] COEF0_RESET = 21'sd32768;

    typedef logic signed [MU_W-1:0]   mu_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [OUT_W-1:0]  series_t;
    typedef logic signed [PW-1:0]     pval_t;
    typedef logic signed [TW-1:0]     term_t;
    typedef logic signed [AW-1:0]     acc_t;

    typedef struct packed {
        pval_t               x;
        pval_t               x2;
        pval_t               x3;
        pval_t               x4;
        pval_t               q;
        term_t               t;
        pval_t [ORDERS-1:0]  p;
        acc_t  [ORDERS-1:0]  acc;
        series_t             sval;
        logic                sat;
    } lse_stage_t;

endpackage

// ----- hdl/lse_point_if.sv -----
interface lse_point_if;
    logic            valid;
    logic            ready;
    lse_pkg::mu_t    mu;

    modport source (output valid, output mu, input ready);
    modport sink (input valid, input mu, output ready);
endinterface

// ----- hdl/lse_result_if.sv -----
interface lse_result_if;
    logic              valid;
    logic              ready;
    lse_pkg::series_t  series_value;
    logic              saturated;

    modport source (output valid, output series_value, output saturated, input ready);
    modport sink (input valid, input series_value, input saturated, output ready);
endinterface

// ----- hdl/legendre_series_eval_top.sv -----
// Channel  | Role          | Payload
// ---------+---------------+--------------------------------------------
// point    | item in       | mu, signed Q1.16
// result   | item out      | series_value signed Q7.16, saturated flag
// APB      | register port | coef_0 .. coef_7 at byte address 4*i
//
// One item enters per cycle unless a stall on the result side reaches the input.
// The pipeline depth is set by the Legendre recurrence, which needs three registered
// steps per order above four, followed by the product, adder tree and rounding.
// Reset clears the valid bits and loads the default coefficients.
// Each stage holds its item when the stage after it is full and stalled, so a
// stall on the result side fills empty stages before input is refused.
module legendre_series_eval_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    lse_point_if.sink                     point,
    lse_result_if.source                  result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lse_pkg::ADDR_W-1:0]    paddr,
    input  logic [lse_pkg::DATA_W-1:0]    pwdata,
    output logic [lse_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    lse_pkg::coef_t      coef_reg [lse_pkg::ORDERS];
    lse_pkg::lse_stage_t stage_reg [lse_pkg::NUM_STAGES];
    lse_pkg::lse_stage_t stage_next [lse_pkg::NUM_STAGES];
    logic [lse_pkg::NUM_STAGES-1:0] valid_reg;
    logic [lse_pkg::NUM_STAGES-1:0] en;
    logic [2:0]                     reg_idx;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;
    assign prdata  = {{(lse_pkg::DATA_W - lse_pkg::COEF_W){1'b0}}, coef_reg[reg_idx]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lse_pkg::ORDERS; i++)
            begin
                coef_reg[i] <= '0;
            end
            coef_reg[0] <= lse_pkg::COEF0_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            coef_reg[reg_idx] <= pwdata[lse_pkg::COEF_W-1:0];
        end
    end

    always_comb
    begin
        en[lse_pkg::NUM_STAGES-1] = !valid_reg[lse_pkg::NUM_STAGES-1] || result.ready;
        for (int k = lse_pkg::NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign point.ready         = en[0];
    assign result.valid        = valid_reg[lse_pkg::NUM_STAGES-1];
    assign result.series_value = stage_reg[lse_pkg::NUM_STAGES-1].sval;
    assign result.saturated    = stage_reg[lse_pkg::NUM_STAGES-1].sat;

    always_comb
    begin
        lse_pkg::lse_stage_t b;
        logic signed [39:0] ma;
        logic signed [39:0] mb;
        logic signed [47:0] mr;
        logic signed [40:0] mc;
        lse_pkg::term_t     w;
        lse_pkg::term_t     v;
        logic signed [27:0] r;

        ma = '0;
        mb = '0;
        mr = '0;
        mc = '0;
        w  = '0;
        v  = '0;
        r  = '0;

        stage_next[0] = '0;
        if (point.mu > lse_pkg::MU_W'(lse_pkg::ONE_Q16))
        begin
            stage_next[0].x = lse_pkg::ONE_Q16;
        end
        else if (point.mu < lse_pkg::MU_W'(lse_pkg::MONE_Q16))
        begin
            stage_next[0].x = lse_pkg::MONE_Q16;
        end
        else
        begin
            stage_next[0].x = lse_pkg::PW'(point.mu);
        end

        for (int k = 1; k < lse_pkg::NUM_STAGES; k++)
        begin
            b = stage_reg[k-1];
            stage_next[k] = b;
            unique case (k)
                1:
                begin
                    ma = b.x * b.x;
                    stage_next[k].x2 = lse_pkg::PW'((ma + 40'sd32768) >>> 16);
                end
                2:
                begin
                    ma = b.x2 * b.x;
                    mb = b.x2 * b.x2;
                    stage_next[k].x3 = lse_pkg::PW'((ma + 40'sd32768) >>> 16);
                    stage_next[k].x4 = lse_pkg::PW'((mb + 40'sd32768) >>> 16);
                    w = 24'sd3 * lse_pkg::TW'(b.x2) - 24'sd65536;
                    stage_next[k].p[2] = lse_pkg::PW'((w + 24'sd1) >>> 1);
                end
                3:
                begin
                    w = 24'sd5 * lse_pkg::TW'(b.x3) - 24'sd3 * lse_pkg::TW'(b.x);
                    v = 24'sd35 * lse_pkg::TW'(b.x4) - 24'sd30 * lse_pkg::TW'(b.x2)
                        + 24'sd196608;
                    stage_next[k].p[0] = lse_pkg::ONE_Q16;
                    stage_next[k].p[1] = b.x;
                    stage_next[k].p[3] = lse_pkg::PW'((w + 24'sd1) >>> 1);
                    stage_next[k].p[4] = lse_pkg::PW'((v + 24'sd4) >>> 3);
                end
                4, 7, 10:
                begin
                    ma = b.x * b.p[(k + 8) / 3 - 0];
                    stage_next[k].q = lse_pkg::PW'((ma + 40'sd32768) >>> 16);
                end
                5:
                begin
                    stage_next[k].t = 24'sd9 * lse_pkg::TW'(b.q) - 24'sd4 * lse_pkg::TW'(b.p[3]);
                end
                8:
                begin
                    stage_next[k].t = 24'sd11 * lse_pkg::TW'(b.q) - 24'sd5 * lse_pkg::TW'(b.p[4]);
                end
                11:
                begin
                    stage_next[k].t = 24'sd13 * lse_pkg::TW'(b.q) - 24'sd6 * lse_pkg::TW'(b.p[5]);
                end
                6:
                begin
                    mr = b.t * lse_pkg::RECIP_5;
                    stage_next[k].p[5] = lse_pkg::PW'((mr + 48'sd524288) >>> 20);
                end
                9:
                begin
                    mr = b.t * lse_pkg::RECIP_6;
                    stage_next[k].p[6] = lse_pkg::PW'((mr + 48'sd524288) >>> 20);
                end
                12:
                begin
                    mr = b.t * lse_pkg::RECIP_7;
                    stage_next[k].p[7] = lse_pkg::PW'((mr + 48'sd524288) >>> 20);
                end
                13:
                begin
                    for (int l = 0; l < lse_pkg::ORDERS; l++)
                    begin
                        mc = coef_reg[l] * b.p[l];
                        if (l < lse_pkg::NUM_TERMS)
                        begin
                            stage_next[k].acc[l] = lse_pkg::AW'(mc);
                        end
                        else
                        begin
                            stage_next[k].acc[l] = '0;
                        end
                    end
                end
                14:
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        stage_next[k].acc[j] = b.acc[2*j] + b.acc[2*j+1];
                    end
                end
                15:
                begin
                    for (int j = 0; j < 2; j++)
                    begin
                        stage_next[k].acc[j] = b.acc[2*j] + b.acc[2*j+1];
                    end
                end
                16:
                begin
                    stage_next[k].acc[0] = b.acc[0] + b.acc[1];
                end
                17:
                begin
                    r = 28'((b.acc[0] + 44'sd32768) >>> 16);
                    if (r > 28'(lse_pkg::OUT_MAX))
                    begin
                        stage_next[k].sval = lse_pkg::OUT_MAX;
                        stage_next[k].sat  = 1'b1;
                    end
                    else if (r < 28'(lse_pkg::OUT_MIN))
                    begin
                        stage_next[k].sval = lse_pkg::OUT_MIN;
                        stage_next[k].sat  = 1'b1;
                    end
                    else
                    begin
                        stage_next[k].sval = lse_pkg::OUT_W'(r);
                        stage_next[k].sat  = 1'b0;
                    end
                end
                default:
                begin
                    stage_next[k] = b;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= point.valid;
            end
            for (int k = 1; k < lse_pkg::NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < lse_pkg::NUM_STAGES; k++)
        begin
            if (en[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

endmodule
